@@ src/first_order_heater_model_core_assert.svh @@
`ifndef FIRST_ORDER_HEATER_MODEL_CORE_ASSERT_SVH
`define FIRST_ORDER_HEATER_MODEL_CORE_ASSERT_SVH
// Assertion helpers for the heater model core.
`define FOHM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FOHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/fohm_pkg.sv @@
package fohm_pkg;

  localparam int TableEntries = 256;
  localparam int FracBits     = 16;
  localparam int ExpSpan      = 16;
  localparam int HeatGain     = 40960;

  localparam logic [1:0] REG_INLET  = 2'd0;
  localparam logic [1:0] REG_FLOW   = 2'd1;
  localparam logic [1:0] REG_BURNER = 2'd2;
  localparam logic [1:0] REG_TAU    = 2'd3;

  typedef struct packed {
    logic [31:0]        timestamp_ms;
    logic signed [15:0] inlet_temp;
    logic [15:0]        flow_rate;
    logic [15:0]        burner_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] outlet_temp;
    logic               saturated;
  } out_item_t;

  // Shared divider request and result.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // e^{-k*Span/N} in Q32: k rounded steps of the per-entry decay es (Q32).
  function automatic logic [32:0] exp_entry(input int k, input logic [63:0] es);
    logic [63:0] e;
    e = 64'h1_0000_0000;
    for (int j = 1; j <= k; j++) begin
      e = (e * es + 64'h8000_0000) >> 32;
    end
    return e[32:0];
  endfunction

endpackage

@@ src/fohm_div.sv @@
module fohm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  fohm_pkg::div_req_t req,
  output fohm_pkg::div_rsp_t rsp
);
  import fohm_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  // One quotient bit per cycle, restoring.
  always_comb begin
    shifted  = {rem_r[31:0], quo_r[63]};
    diff     = shifted - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ src/fohm_mul.sv @@
module fohm_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic [64:0] p
);
  // Registered multiplier shared by all product steps.
  always_ff @(posedge clk) begin
    p <= 65'(a) * 65'(b);
  end
endmodule

@@ src/first_order_heater_model_core.sv @@
// Heater model core: one item at a time through a shared divider and multiplier.
// Items do not overlap: in_stall is high while an item is in work.
// Reset (rst_n low, synchronous) loads register defaults; the divider then rebuilds
// the steady state, and again after each initial write.
module first_order_heater_model_core #(
  parameter int EXP_TABLE_ENTRIES = fohm_pkg::TableEntries,
  parameter int FRACTION_BITS     = fohm_pkg::FracBits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fohm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fohm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import fohm_pkg::*;
  `include "first_order_heater_model_core_assert.svh"

  localparam int IdxW = $clog2(EXP_TABLE_ENTRIES);
  localparam logic [FRACTION_BITS:0] AlphaOne = {1'b1, {FRACTION_BITS{1'b0}}};

  // Per-entry decay e^{-Span/N} in Q32 from a floor-term Taylor series.
  localparam logic [63:0] ExpOne = 64'h1_0000_0000;
  localparam logic [63:0] ExpDen = 64'(EXP_TABLE_ENTRIES);
  localparam logic [63:0] ExpT1  = ExpOne * 64'(ExpSpan) / ExpDen;
  localparam logic [63:0] ExpT2  = ExpT1 * 64'(ExpSpan) / (ExpDen * 64'd2);
  localparam logic [63:0] ExpT3  = ExpT2 * 64'(ExpSpan) / (ExpDen * 64'd3);
  localparam logic [63:0] ExpT4  = ExpT3 * 64'(ExpSpan) / (ExpDen * 64'd4);
  localparam logic [63:0] ExpT5  = ExpT4 * 64'(ExpSpan) / (ExpDen * 64'd5);
  localparam logic [63:0] ExpT6  = ExpT5 * 64'(ExpSpan) / (ExpDen * 64'd6);
  localparam logic [63:0] ExpT7  = ExpT6 * 64'(ExpSpan) / (ExpDen * 64'd7);
  localparam logic [63:0] ExpT8  = ExpT7 * 64'(ExpSpan) / (ExpDen * 64'd8);
  localparam logic [63:0] ExpT9  = ExpT8 * 64'(ExpSpan) / (ExpDen * 64'd9);
  localparam logic [63:0] ExpT10 = ExpT9 * 64'(ExpSpan) / (ExpDen * 64'd10);
  localparam logic [63:0] ExpT11 = ExpT10 * 64'(ExpSpan) / (ExpDen * 64'd11);
  localparam logic [63:0] ExpT12 = ExpT11 * 64'(ExpSpan) / (ExpDen * 64'd12);
  localparam logic [63:0] ExpT13 = ExpT12 * 64'(ExpSpan) / (ExpDen * 64'd13);
  localparam logic [63:0] ExpT14 = ExpT13 * 64'(ExpSpan) / (ExpDen * 64'd14);
  localparam logic [63:0] ExpT15 = ExpT14 * 64'(ExpSpan) / (ExpDen * 64'd15);
  localparam logic [63:0] ExpT16 = ExpT15 * 64'(ExpSpan) / (ExpDen * 64'd16);
  localparam logic [63:0] ExpT17 = ExpT16 * 64'(ExpSpan) / (ExpDen * 64'd17);
  localparam logic [63:0] ExpT18 = ExpT17 * 64'(ExpSpan) / (ExpDen * 64'd18);
  localparam logic [63:0] ExpT19 = ExpT18 * 64'(ExpSpan) / (ExpDen * 64'd19);
  localparam logic [63:0] ExpT20 = ExpT19 * 64'(ExpSpan) / (ExpDen * 64'd20);
  localparam logic [63:0] ExpT21 = ExpT20 * 64'(ExpSpan) / (ExpDen * 64'd21);
  localparam logic [63:0] ExpT22 = ExpT21 * 64'(ExpSpan) / (ExpDen * 64'd22);
  localparam logic [63:0] ExpT23 = ExpT22 * 64'(ExpSpan) / (ExpDen * 64'd23);
  localparam logic [63:0] ExpT24 = ExpT23 * 64'(ExpSpan) / (ExpDen * 64'd24);
  localparam logic [63:0] ExpPlus = ExpOne + ExpT2 + ExpT4 + ExpT6 + ExpT8 + ExpT10
                                    + ExpT12 + ExpT14 + ExpT16 + ExpT18 + ExpT20
                                    + ExpT22 + ExpT24;
  localparam logic [63:0] ExpMinus = ExpT1 + ExpT3 + ExpT5 + ExpT7 + ExpT9 + ExpT11
                                     + ExpT13 + ExpT15 + ExpT17 + ExpT19 + ExpT21
                                     + ExpT23;
  localparam logic [63:0] ExpStep = ExpPlus - ExpMinus;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_TDIV   = 11'b00000000010,
    S_TWAIT  = 11'b00000000100,
    S_PDIV   = 11'b00000001000,
    S_PWAIT  = 11'b00000010000,
    S_INTERP = 11'b00000100000,
    S_IWAIT  = 11'b00001000000,
    S_STEP   = 11'b00010000000,
    S_SWAIT  = 11'b00100000000,
    S_DONE   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0]     ini_in_r;
  logic [15:0]            ini_flow_r, ini_burn_r, tau_r;
  logic signed [15:0]     p_in_r;
  logic [15:0]            p_flow_r, p_burn_r;
  logic signed [15:0]     p_out_r;
  logic [31:0]            p_time_r;
  logic                   first_r;
  logic                   reload_r;
  logic                   init_busy_r;
  in_item_t               item_r;
  logic signed [16:0]     target_r;
  logic                   sat_r;
  logic [63:0]            pos_r;
  logic [FRACTION_BITS:0] alpha_r;
  out_item_t              res_r;
  logic                   ovalid_r;
  logic [32:0]            tab [EXP_TABLE_ENTRIES+1];

  div_req_t dreq;
  div_rsp_t drsp;
  logic [32:0] ma;
  logic [31:0] mb;
  logic [64:0] mp;

  fohm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  fohm_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_tab
    assign tab[g] = exp_entry(g, ExpStep);
  end

  logic                   in_acc, out_acc, cfg_init;
  logic [31:0]            dt;
  logic [IdxW:0]          idx;
  logic                   far;
  logic [15:0]            frac;
  logic [32:0]            e0, e1;
  logic [32:0]            e_int;
  logic signed [17:0]     tsum;
  logic signed [16:0]     tclamp;
  logic                   tsat;
  logic [33:0]            araw;
  logic [FRACTION_BITS:0] alpha_new;
  logic signed [17:0]     diff;
  logic [16:0]            mag;
  logic [47:0]            q;
  logic signed [17:0]     nout;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign cfg_init = cfg_we && (cfg_index != REG_TAU);
  assign in_stall = (state_r != S_IDLE) || ovalid_r || reload_r || init_busy_r || cfg_we;
  assign dt       = item_r.timestamp_ms - p_time_r;
  assign idx      = pos_r[16+IdxW:16];
  assign far      = pos_r[63:16] >= 48'(EXP_TABLE_ENTRIES);
  assign frac     = pos_r[15:0];
  assign e0       = tab[idx];
  assign e1       = tab[idx + (IdxW+1)'(1)];
  assign tsum     = 18'(p_in_r) + 18'(drsp.quo[16:0]);

  // A quotient of 2^16 or more saturates the target whatever the inlet.
  always_comb begin
    tsat   = 1'b0;
    tclamp = 17'(tsum);
    if (p_flow_r == 16'd0) begin
      tsat = 1'b1; tclamp = 17'sd32767;
    end else if (drsp.quo[63:16] != '0 || tsum > 18'sd32767) begin
      tsat = 1'b1; tclamp = 17'sd32767;
    end else if (tsum < -18'sd32768) begin
      tsat = 1'b1; tclamp = -17'sd32768;
    end
  end

  // Alpha from the interpolated exponential, clamped to one.
  assign e_int     = e0 - 33'(mp >> 16);
  assign araw      = (34'h1_0000_0000 - 34'(e_int) + (34'd1 << (31 - FRACTION_BITS)))
                     >> (32 - FRACTION_BITS);
  assign alpha_new = (araw > 34'(AlphaOne)) ? AlphaOne : (FRACTION_BITS+1)'(araw);

  assign diff = 18'(target_r) - 18'(p_out_r);
  assign mag  = diff[17] ? 17'(-diff) : 17'(diff);
  assign q    = 48'((mp + (65'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS);
  assign nout = diff[17] ? 18'(p_out_r) - 18'(q) : 18'(p_out_r) + 18'(q);

  always_comb begin
    dreq = '0;
    ma   = '0;
    mb   = '0;
    case (state_r)
      S_TDIV: begin
        dreq.start = 1'b1;
        dreq.num   = 64'(HeatGain) * 64'(p_burn_r) + 64'(p_flow_r >> 1);
        dreq.den   = 32'(p_flow_r);
      end
      S_PDIV: begin
        dreq.start = 1'b1;
        dreq.num   = (64'(dt) * 64'(EXP_TABLE_ENTRIES)) << 16;
        dreq.den   = 32'(ExpSpan) * 32'(tau_r);
      end
      S_INTERP: begin
        ma = e0 - e1;
        mb = 32'(frac);
      end
      // Hold the operands so the product is still there when the item ends.
      S_STEP, S_SWAIT: begin
        ma = 33'(mag);
        mb = 32'(alpha_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (reload_r || in_acc) state_nxt = S_TDIV;
      S_TDIV:   state_nxt = S_TWAIT;
      S_TWAIT:  if (drsp.done) begin
                  if (init_busy_r || first_r) state_nxt = S_OUT;
                  else if (tau_r == 16'd0) state_nxt = S_STEP;
                  else state_nxt = S_PDIV;
                end
      S_PDIV:   state_nxt = S_PWAIT;
      S_PWAIT:  if (drsp.done) state_nxt = S_INTERP;
      S_INTERP: state_nxt = far ? S_STEP : S_IWAIT;
      S_IWAIT:  state_nxt = S_STEP;
      S_STEP:   state_nxt = S_SWAIT;
      S_SWAIT:  state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ini_in_r    <= 16'sd1280;
      ini_flow_r  <= 16'd1024;
      ini_burn_r  <= 16'd0;
      tau_r       <= 16'd300;
      p_in_r      <= 16'sd1280;
      p_flow_r    <= 16'd1024;
      p_burn_r    <= 16'd0;
      p_time_r    <= '0;
      first_r     <= 1'b1;
      reload_r    <= 1'b1;
      init_busy_r <= 1'b0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) ovalid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_INLET:  ini_in_r   <= cfg_wdata;
          REG_FLOW:   ini_flow_r <= cfg_wdata;
          REG_BURNER: ini_burn_r <= cfg_wdata;
          REG_TAU:    tau_r      <= cfg_wdata;
          default: ;
        endcase
      end
      if (cfg_init && first_r) reload_r <= 1'b1;
      if (state_r == S_IDLE && reload_r && !cfg_we) begin
        reload_r    <= 1'b0;
        init_busy_r <= 1'b1;
        p_in_r      <= ini_in_r;
        p_flow_r    <= ini_flow_r;
        p_burn_r    <= ini_burn_r;
      end else if (state_r == S_IDLE && in_acc) begin
        item_r <= in_data;
      end
      if (state_r == S_TWAIT && drsp.done) begin
        target_r <= tclamp;
        sat_r    <= tsat;
        alpha_r  <= AlphaOne;
        if (init_busy_r) begin
          p_out_r <= 16'(tclamp);
        end
      end
      if (state_r == S_PWAIT && drsp.done) pos_r <= drsp.quo;
      if (state_r == S_IWAIT) alpha_r <= alpha_new;
      if (state_r == S_OUT) begin
        if (init_busy_r) init_busy_r <= 1'b0;
        else begin
          first_r          <= 1'b0;
          p_time_r         <= item_r.timestamp_ms;
          ovalid_r         <= 1'b1;
          res_r.outlet_temp <= p_out_r;
          res_r.saturated  <= sat_r;
        end
      end
      if (state_r == S_DONE) begin
        ovalid_r <= 1'b1;
        res_r.saturated <= sat_r || nout > 18'sd32767 || nout < -18'sd32768;
        if (nout > 18'sd32767) begin
          res_r.outlet_temp <= 16'sd32767; p_out_r <= 16'sd32767;
        end else if (nout < -18'sd32768) begin
          res_r.outlet_temp <= -16'sd32768; p_out_r <= -16'sd32768;
        end else begin
          res_r.outlet_temp <= 16'(nout); p_out_r <= 16'(nout);
        end
        p_in_r   <= item_r.inlet_temp;
        p_flow_r <= item_r.flow_rate;
        p_burn_r <= item_r.burner_rate;
        p_time_r <= item_r.timestamp_ms;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  `FOHM_ASSERT_IMPL(a_no_accept_busy, state_r != S_IDLE, !in_acc,
                    "item accepted while busy")
  `FOHM_ASSERT_NEXT(a_done_gives_out, state_r == S_DONE, out_valid,
                    "finished item not presented")
  `FOHM_ASSERT_IMPL(a_div_start_idle, dreq.start, state_r == S_TDIV || state_r == S_PDIV,
                    "divider started outside a divide step")

endmodule

@@ verif/tb_first_order_heater_model_core.sv @@
`timescale 1ns / 1ps

class heater_scoreboard;
  localparam int N = fohm_pkg::TableEntries;
  localparam int FB = fohm_pkg::FracBits;

  longint unsigned decay_q32[N+1];
  logic signed [15:0] init_inlet, last_inlet, last_outlet;
  logic [15:0] init_flow, init_burner, tau_ms, last_flow, last_burner;
  logic [31:0] last_ts;
  bit awaiting_first;
  fohm_pkg::out_item_t outlet_q[$];
  int errors;

  function new();
    longint unsigned term, plus, minus, es;
    term = 64'h1_0000_0000;
    plus = term;
    minus = 0;
    for (int n = 1; n <= 24; n++) begin
      term = term * fohm_pkg::ExpSpan / (64'(N) * 64'(n));
      if (n % 2 == 1) minus += term;
      else plus += term;
    end
    es = plus - minus;
    decay_q32[0] = 64'h1_0000_0000;
    for (int k = 1; k <= N; k++)
      decay_q32[k] = (decay_q32[k-1] * es + 64'h8000_0000) >> 32;
    init_inlet = 16'sd1280;
    init_flow = 16'd1024;
    init_burner = 16'd0;
    tau_ms = 16'd300;
    last_ts = '0;
    awaiting_first = 1;
    errors = 0;
    reload();
  endfunction

  function int target_temp(logic signed [15:0] tin, logic [15:0] flow,
                           logic [15:0] burner, output bit sat);
    longint t;
    sat = 1;
    if (flow == 0) return 32767;
    t = longint'(tin) + longint'((64'(fohm_pkg::HeatGain) * burner + flow / 2) / flow);
    if (t > 32767) return 32767;
    if (t < -32768) return -32768;
    sat = 0;
    return int'(t);
  endfunction

  function void reload();
    bit sat;
    last_inlet = init_inlet;
    last_flow = init_flow;
    last_burner = init_burner;
    last_outlet = 16'(target_temp(last_inlet, last_flow, last_burner, sat));
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      fohm_pkg::REG_INLET: init_inlet = val;
      fohm_pkg::REG_FLOW: init_flow = val;
      fohm_pkg::REG_BURNER: init_burner = val;
      fohm_pkg::REG_TAU: tau_ms = val;
      default: ;
    endcase
    if (idx != fohm_pkg::REG_TAU && awaiting_first) reload();
  endfunction

  function longint unsigned lag_gain(logic [31:0] dt);
    longint unsigned full, pos, idx, f, e, a;
    full = 64'd1 << FB;
    if (tau_ms == 0) return full;
    pos = ((64'(dt) * N) << 16) / (64'(fohm_pkg::ExpSpan) * tau_ms);
    idx = pos >> 16;
    if (idx >= N) return full;
    f = pos & 64'hFFFF;
    e = decay_q32[idx] - (((decay_q32[idx] - decay_q32[idx+1]) * f) >> 16);
    a = (64'h1_0000_0000 - e + (64'd1 << (31 - FB))) >> (32 - FB);
    return (a > full) ? full : a;
  endfunction

  function void note_input(fohm_pkg::in_item_t x);
    fohm_pkg::out_item_t r;
    bit sat;
    int target;
    longint diff, q;
    target = target_temp(last_inlet, last_flow, last_burner, sat);
    if (awaiting_first) begin
      awaiting_first = 0;
      last_ts = x.timestamp_ms;
      r.outlet_temp = last_outlet;
    end else begin
      diff = longint'(target) - longint'(last_outlet);
      q = ((diff < 0 ? -diff : diff) * longint'(lag_gain(x.timestamp_ms - last_ts))
           + (64'd1 << (FB - 1))) >>> FB;
      diff = (diff < 0) ? longint'(last_outlet) - q : longint'(last_outlet) + q;
      if (diff > 32767) begin
        diff = 32767;
        sat = 1;
      end
      if (diff < -32768) begin
        diff = -32768;
        sat = 1;
      end
      last_outlet = 16'(diff);
      r.outlet_temp = last_outlet;
      last_inlet = x.inlet_temp;
      last_flow = x.flow_rate;
      last_burner = x.burner_rate;
      last_ts = x.timestamp_ms;
    end
    r.saturated = sat;
    outlet_q.push_back(r);
  endfunction

  function void check(fohm_pkg::out_item_t got);
    fohm_pkg::out_item_t want;
    if (outlet_q.size() == 0) begin
      $display("%0t: unexpected item outlet_temp=%0d saturated=%0b", $time,
               got.outlet_temp, got.saturated);
      errors++;
      return;
    end
    want = outlet_q.pop_front();
    if (got.outlet_temp !== want.outlet_temp) begin
      $display("%0t: outlet_temp expected %0d actual %0d", $time,
               want.outlet_temp, got.outlet_temp);
      errors++;
    end
    if (got.saturated !== want.saturated) begin
      $display("%0t: saturated expected %0b actual %0b", $time,
               want.saturated, got.saturated);
      errors++;
    end
  endfunction
endclass

module tb_first_order_heater_model_core;
  import fohm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_INLET;
  logic [15:0] cfg_wdata = '0;

  heater_scoreboard sb = new();
  bit idling = 1;
  int quiet_cycles = 0;
  logic [31:0] ts_now = '0;

  first_order_heater_model_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Drain results and toggle backpressure.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check(out_data);
      out_stall <= idling && ($urandom_range(99) < 37);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("first_order_heater_model_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send(logic [31:0] ts, logic [15:0] inlet, logic [15:0] flow,
                      logic [15:0] burner);
    in_item_t x;
    x.timestamp_ms = ts;
    x.inlet_temp = inlet;
    x.flow_rate = flow;
    x.burner_rate = burner;
    while (idling && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    sb.note_input(x);
    ts_now = ts;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.outlet_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
    // give the block time to rebuild its steady state
    repeat (300) @(posedge clk);
  endtask

  task automatic random_items(int count);
    logic [31:0] dt;
    logic [15:0] flow, burner;
    int span;
    for (int i = 0; i < count; i++) begin
      span = 3 * sb.tau_ms + 5;
      case ($urandom_range(9))
        0: dt = $urandom;
        1: dt = $urandom_range(3);
        2: dt = $urandom_range(200000, 5000000);
        default: dt = $urandom_range(span);
      endcase
      case ($urandom_range(9))
        0: flow = 0;
        1, 2, 3: flow = 16'($urandom);
        default: flow = 16'($urandom_range(512, 4096));
      endcase
      burner = ($urandom_range(9) < 4) ? 16'($urandom) : 16'($urandom_range(2000));
      idling = !(i >= count / 3 && i < count / 3 + 40);
      send(ts_now + dt, 16'($urandom), flow, burner);
    end
    idling = 1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // initial writes reload the steady state while no item has come
    write_reg(REG_INLET, 16'h8000);
    write_reg(REG_FLOW, 16'd0);
    write_reg(REG_FLOW, 16'd1);
    write_reg(REG_BURNER, 16'hFFFF);
    write_reg(REG_INLET, 16'd1600);
    write_reg(REG_FLOW, 16'd1024);
    write_reg(REG_BURNER, 16'd100);
    write_reg(REG_TAU, 16'd300);

    send(32'hFFFF_FF00, 16'h7FFF, 16'd0, 16'hFFFF);
    send(32'h0000_0010, 16'h8000, 16'd0, 16'd0);
    send(32'h0000_0010, 16'h7FFF, 16'd1, 16'hFFFF);
    send(32'h0000_0100, 16'h8000, 16'hFFFF, 16'd0);
    send(32'h0000_0200, 16'd0, 16'd1024, 16'd0);
    send(32'h0010_0000, 16'd1280, 16'd1, 16'hFFFF);
    send(32'h0000_0001, 16'h8000, 16'hFFFF, 16'hFFFF);
    send(32'h0000_0050, 16'd1280, 16'd2048, 16'd320);
    send(32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF, 16'd1);
    send(32'h0000_012C, 16'h5555, 16'hAAAA, 16'h5555);
    send(32'h0000_0258, 16'hAAAA, 16'h5555, 16'hAAAA);
    send(32'h0000_0300, 16'd1280, 16'd1024, 16'd0);
    random_items(180);

    drain();
    write_reg(REG_TAU, 16'd1);
    write_reg(REG_INLET, 16'h7FFF);
    random_items(180);
    drain();
    write_reg(REG_TAU, 16'hFFFF);
    write_reg(REG_FLOW, 16'hFFFF);
    random_items(180);
    drain();
    write_reg(REG_TAU, 16'd0);
    write_reg(REG_BURNER, 16'hFFFF);
    random_items(180);
    drain();
    write_reg(REG_TAU, 16'($urandom_range(20, 2000)));
    random_items(180);
    drain();
    write_reg(REG_TAU, 16'd300);
    write_reg(REG_INLET, 16'h8000);
    write_reg(REG_FLOW, 16'd0);
    write_reg(REG_BURNER, 16'd0);
    random_items(180);
    drain();

    if (sb.errors == 0 && sb.outlet_q.size() == 0)
      $display("first_order_heater_model_core: match");
    else
      $display("first_order_heater_model_core: mismatch");
    $finish;
  end
endmodule
